### sv/linear_hash_table_unit_assert.svh
// Assertion macros used by the port checker file of the hash table unit.
`ifndef LINEAR_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LHT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hash table unit: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hash table unit: assertion failed");

`endif

### sv/lht_pkg.sv
// ----------------------------------------------------------------------------
// lht_pkg
// Types, codes and default sizes of the linear hashing table unit.
// ----------------------------------------------------------------------------
package lht_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DUP  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // split bookkeeping flags
   localparam logic [3:0] LO_SEEN = 4'd1;
   localparam logic [3:0] LO_SET  = 4'd2;
   localparam logic [3:0] HI_SEEN = 4'd4;
   localparam logic [3:0] HI_SET  = 4'd8;

   typedef struct packed {
      logic        kind;
      logic [63:0] key;
      logic [31:0] key_hash;
      logic [31:0] record_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [7:0]  slot_index;
      logic [31:0] found_value;
   } rsp_type;

endpackage

### sv/linear_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_hash_table_unit
// Linear hashing table in one slot memory: search, and insert with bucket split.
// ----------------------------------------------------------------------------
//   channel  ports                           handshake
//   request  start, busy, req_data          taken when start high and busy low
//   result   rsp_strobe, rsp_data           one cycle, no back-pressure
//   config   csr_valid, csr_ready, csr_wdata written when valid and ready high
//
// One item at a time; results cannot be stalled. A search starts, then reads and
// checks each chain slot visited, and stops with a miss when the walk runs off the
// chain end; its result beat follows in the next cycle. An insert checks for room,
// reads and sorts each slot of the split bucket, ends the split, places the entry,
// walks a relinked chain and counts; a unique insert runs the search first. Reset
// empties the table: slots are never cleared.
// ----------------------------------------------------------------------------
module linear_hash_table_unit #(
   parameter int CAPACITY   = lht_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = lht_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lht_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lht_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lht_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);

   localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW    = IW + 1;
   localparam int SW    = IW + 2;
   localparam int ROW_W = KEY_BITS + 32 + VALUE_BITS + CW;
   localparam logic [CW-1:0] NIL = CW'(CAPACITY);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_F_START  = 4'd1;
   localparam logic [3:0] ST_F_RD     = 4'd2;
   localparam logic [3:0] ST_F_CHK    = 4'd3;
   localparam logic [3:0] ST_I_START  = 4'd4;
   localparam logic [3:0] ST_SP_RD    = 4'd5;
   localparam logic [3:0] ST_SP_CHK   = 4'd6;
   localparam logic [3:0] ST_SP_ENDLO = 4'd7;
   localparam logic [3:0] ST_SP_ENDHI = 4'd8;
   localparam logic [3:0] ST_PL_START = 4'd9;
   localparam logic [3:0] ST_PL_MOVE  = 4'd10;
   localparam logic [3:0] ST_PL_NEW   = 4'd11;
   localparam logic [3:0] ST_RL_RD    = 4'd12;
   localparam logic [3:0] ST_RL_CHK   = 4'd13;
   localparam logic [3:0] ST_FIN      = 4'd14;

   logic [ROW_W-1:0] slot_mem_ff [CAPACITY];
   logic [ROW_W-1:0] rd_row_ff;

   logic [3:0]            state_ff, state_in;
   logic                  kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [31:0]           hash_ff, hash_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  uniq_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [SW-1:0]         span_ff, span_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         n_ff, n_in;
   logic                  first_ff, first_in;
   logic [3:0]            flag_ff, flag_in;
   logic [CW-1:0]         glo_ff, glo_in, ghi_ff, ghi_in, empty_ff, empty_in;
   logic [CW-1:0]         sfirst_ff, sfirst_in, pos_ff, pos_in, home_ff, home_in;
   logic [KEY_BITS-1:0]   lk_ff, lk_in, hk_ff, hk_in;
   logic [31:0]           lh_ff, lh_in, hh_ff, hh_in;
   logic [VALUE_BITS-1:0] lv_ff, lv_in, hv_ff, hv_in;
   lht_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;

   logic                  wr_en, rd_en;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [ROW_W-1:0]      wr_row;

   logic [KEY_BITS-1:0]   rd_key;
   logic [31:0]           rd_hash;
   logic [VALUE_BITS-1:0] rd_val;
   logic [CW-1:0]         rd_link;
   logic [CW-1:0]         half_cw, cur_mask, ins_pos, ins_home;
   logic                  f_miss;

   assign rd_link = rd_row_ff[CW-1:0];
   assign rd_val  = rd_row_ff[CW +: VALUE_BITS];
   assign rd_hash = rd_row_ff[CW + VALUE_BITS +: 32];
   assign rd_key  = rd_row_ff[CW + VALUE_BITS + 32 +: KEY_BITS];

   function automatic logic [CW-1:0] span_mask(input logic [31:0] h,
                                              input logic [SW-1:0] span,
                                              input logic [CW-1:0] cnt);
      logic [SW-1:0] full_m;
      logic [SW-1:0] half_m;
      logic [CW-1:0] full;
      full_m = span - SW'(1);
      half_m = (span >> 1) - SW'(1);
      full   = h[CW-1:0] & full_m[CW-1:0];
      if (full < cnt) begin
         return full;
      end
      return h[CW-1:0] & half_m[CW-1:0];
   endfunction

   assign half_cw  = CW'(span_ff >> 1);
   assign cur_mask = span_mask(rd_hash, span_ff, count_ff);
   assign ins_pos  = span_mask(hash_ff, span_ff, count_ff + CW'(1));
   assign ins_home = span_mask(rd_hash, span_ff, count_ff + CW'(1));

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= slot_mem_ff[rd_addr];
      end
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      key_in    = key_ff;
      hash_in   = hash_ff;
      val_in    = val_ff;
      count_in  = count_ff;
      span_in   = span_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      flag_in   = flag_ff;
      glo_in    = glo_ff;
      ghi_in    = ghi_ff;
      empty_in  = empty_ff;
      sfirst_in = sfirst_ff;
      pos_in    = pos_ff;
      home_in   = home_ff;
      lk_in     = lk_ff;
      lh_in     = lh_ff;
      lv_in     = lv_ff;
      hk_in     = hk_ff;
      hh_in     = hh_ff;
      hv_in     = hv_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_row    = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      f_miss    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in = req_data.kind;
               key_in  = KEY_BITS'(req_data.key);
               hash_in = req_data.key_hash;
               val_in  = VALUE_BITS'(req_data.record_value);
               if (req_data.kind == lht_pkg::KIND_SEARCH || uniq_ff) begin
                  state_in = ST_F_START;
               end else begin
                  state_in = ST_I_START;
               end
            end
         end
         ST_F_START: begin
            if (count_ff == '0) begin
               f_miss = 1'b1;
            end else begin
               idx_in   = span_mask(hash_ff, span_ff, count_ff);
               first_in = 1'b1;
               n_in     = '0;
               state_in = ST_F_RD;
            end
         end
         ST_F_RD: begin
            if (n_ff == NIL || idx_ff >= NIL) begin
               f_miss = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (rd_key == key_ff) begin
               rsp_in = '0;
               if (kind_ff == lht_pkg::KIND_SEARCH) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.slot_index  = 8'(idx_ff);
                  rsp_in.found_value = 32'(rd_val);
               end else begin
                  rsp_in.status = lht_pkg::STATUS_DUP;
               end
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (first_ff && cur_mask != idx_ff) begin
               f_miss = 1'b1;
            end else begin
               idx_in   = rd_link;
               first_in = 1'b0;
               n_in     = n_ff + CW'(1);
               state_in = ST_F_RD;
            end
         end
         ST_I_START: begin
            if (count_ff >= NIL) begin
               rsp_in        = '0;
               rsp_in.status = lht_pkg::STATUS_FULL;
               strobe_in     = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               empty_in = count_ff;
               if (half_cw == '0) begin
                  state_in = ST_PL_START;
               end else begin
                  sfirst_in = count_ff - half_cw;
                  idx_in    = count_ff - half_cw;
                  flag_in   = '0;
                  n_in      = '0;
                  state_in  = ST_SP_RD;
               end
            end
         end
         ST_SP_RD: begin
            if (n_ff == NIL || idx_ff >= NIL) begin
               state_in = ST_SP_ENDLO;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = ST_SP_CHK;
            end
         end
         ST_SP_CHK: begin
            if (flag_ff == '0 && cur_mask != sfirst_ff) begin
               state_in = ST_SP_ENDLO;
            end else begin
               if ((rd_hash[CW-1:0] & half_cw) == '0) begin
                  if ((flag_ff & lht_pkg::LO_SEEN) == '0) begin
                     if ((flag_ff & lht_pkg::HI_SEEN) != '0) begin
                        flag_in  = lht_pkg::LO_SEEN | lht_pkg::HI_SEEN;
                        glo_in   = empty_ff;
                        empty_in = idx_ff;
                     end else begin
                        flag_in = lht_pkg::LO_SEEN | lht_pkg::LO_SET;
                        glo_in  = idx_ff;
                     end
                  end else begin
                     if ((flag_ff & lht_pkg::LO_SET) == '0) begin
                        wr_en   = (glo_ff < NIL);
                        wr_addr = glo_ff[IW-1:0];
                        wr_row  = {lk_ff, lh_ff, lv_ff, idx_ff};
                        flag_in = (flag_ff & lht_pkg::HI_SEEN) | lht_pkg::LO_SEEN
                                  | lht_pkg::LO_SET;
                     end
                     glo_in = idx_ff;
                  end
                  lk_in = rd_key;
                  lh_in = rd_hash;
                  lv_in = rd_val;
               end else begin
                  if ((flag_ff & lht_pkg::HI_SEEN) == '0) begin
                     flag_in  = (flag_ff & lht_pkg::LO_SEEN) | lht_pkg::HI_SEEN;
                     ghi_in   = empty_ff;
                     empty_in = idx_ff;
                  end else begin
                     if ((flag_ff & lht_pkg::HI_SET) == '0) begin
                        wr_en   = (ghi_ff < NIL);
                        wr_addr = ghi_ff[IW-1:0];
                        wr_row  = {hk_ff, hh_ff, hv_ff, idx_ff};
                        flag_in = (flag_ff & lht_pkg::LO_SEEN) | lht_pkg::HI_SEEN
                                  | lht_pkg::HI_SET;
                     end
                     ghi_in = idx_ff;
                  end
                  hk_in = rd_key;
                  hh_in = rd_hash;
                  hv_in = rd_val;
               end
               idx_in   = rd_link;
               n_in     = n_ff + CW'(1);
               state_in = ST_SP_RD;
            end
         end
         ST_SP_ENDLO: begin
            // close the low chain if its tail is still pending
            if ((flag_ff & (lht_pkg::LO_SEEN | lht_pkg::LO_SET)) == lht_pkg::LO_SEEN) begin
               wr_en   = (glo_ff < NIL);
               wr_addr = glo_ff[IW-1:0];
               wr_row  = {lk_ff, lh_ff, lv_ff, NIL};
            end
            state_in = ST_SP_ENDHI;
         end
         ST_SP_ENDHI: begin
            if ((flag_ff & (lht_pkg::HI_SEEN | lht_pkg::HI_SET)) == lht_pkg::HI_SEEN) begin
               wr_en   = (ghi_ff < NIL);
               wr_addr = ghi_ff[IW-1:0];
               wr_row  = {hk_ff, hh_ff, hv_ff, NIL};
            end
            state_in = ST_PL_START;
         end
         ST_PL_START: begin
            pos_in = ins_pos;
            if (ins_pos >= NIL || empty_ff >= NIL) begin
               state_in = ST_FIN;
            end else if (ins_pos == empty_ff) begin
               wr_en    = 1'b1;
               wr_addr  = ins_pos[IW-1:0];
               wr_row   = {key_ff, hash_ff, val_ff, NIL};
               state_in = ST_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ins_pos[IW-1:0];
               state_in = ST_PL_MOVE;
            end
         end
         ST_PL_MOVE: begin
            // move the foreign occupant to the free slot
            wr_en    = 1'b1;
            wr_addr  = empty_ff[IW-1:0];
            wr_row   = rd_row_ff;
            home_in  = ins_home;
            state_in = ST_PL_NEW;
         end
         ST_PL_NEW: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[IW-1:0];
            if (home_ff == pos_ff) begin
               wr_row   = {key_ff, hash_ff, val_ff, empty_ff};
               state_in = ST_FIN;
            end else begin
               wr_row   = {key_ff, hash_ff, val_ff, NIL};
               idx_in   = home_ff;
               n_in     = '0;
               state_in = ST_RL_RD;
            end
         end
         ST_RL_RD: begin
            if (n_ff == NIL || idx_ff >= NIL) begin
               state_in = ST_FIN;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = ST_RL_CHK;
            end
         end
         ST_RL_CHK: begin
            if (rd_link == pos_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[IW-1:0];
               wr_row   = {rd_key, rd_hash, rd_val, empty_ff};
               state_in = ST_FIN;
            end else begin
               idx_in   = rd_link;
               n_in     = n_ff + CW'(1);
               state_in = ST_RL_RD;
            end
         end
         ST_FIN: begin
            count_in = count_ff + CW'(1);
            if (SW'(count_ff) + SW'(1) == span_ff) begin
               span_in = span_ff << 1;
            end
            rsp_in    = '0;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a miss answers a search, or lets a unique insert go on
      if (f_miss) begin
         if (kind_ff == lht_pkg::KIND_SEARCH) begin
            rsp_in    = '0;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end else begin
            state_in = ST_I_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         span_ff   <= SW'(1);
         uniq_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         span_ff   <= span_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            uniq_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      hash_ff   <= hash_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      first_ff  <= first_in;
      flag_ff   <= flag_in;
      glo_ff    <= glo_in;
      ghi_ff    <= ghi_in;
      empty_ff  <= empty_in;
      sfirst_ff <= sfirst_in;
      pos_ff    <= pos_in;
      home_ff   <= home_in;
      lk_ff     <= lk_in;
      lh_ff     <= lh_in;
      lv_ff     <= lv_in;
      hk_ff     <= hk_in;
      hh_ff     <= hh_in;
      hv_ff     <= hv_in;
      rsp_ff    <= rsp_in;
   end

endmodule

### sv/lht_checker.sv
// ----------------------------------------------------------------------------
// lht_port_checks
// Port-level checks of the hash table unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_hash_table_unit_assert.svh"

module lht_port_checks (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input lht_pkg::rsp_type rsp_data
);

   `LHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `LHT_ASSERT_NOW(a_strobe_after_work, rsp_strobe, $past(busy))
   `LHT_ASSERT_NEXT(a_single_beat, rsp_strobe, !rsp_strobe)
   `LHT_ASSERT_NOW(a_hit_is_ok, rsp_strobe && rsp_data.found,
                   rsp_data.status == lht_pkg::STATUS_OK)

endmodule

bind linear_hash_table_unit lht_port_checks u_lht_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

### tb/lht_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lht_checker
// Watches the request, result and register channels of the hash table unit,
// keeps its own copy of the slot array and predicts every result beat.
// ----------------------------------------------------------------------------
module lht_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lht_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  lht_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_wdata,
   output int               fail_count,
   output int               pending
);

   localparam int CAP = lht_pkg::CAPACITY_DEF;
   localparam int NIL = CAP;

   logic [63:0]      tbl_key [CAP];
   logic [31:0]      tbl_hash [CAP];
   logic [31:0]      tbl_val [CAP];
   int               tbl_link [CAP];
   int               n_entries;
   int               span;
   logic             uniq;
   lht_pkg::rsp_type expected_q[$];

   function automatic int bucket_of(logic [31:0] h, int sp, int cnt);
      int full;
      full = int'(h & (sp - 1));
      if (full < cnt) return full;
      return int'(h & ((sp >> 1) - 1));
   endfunction

   function automatic void store(int s, logic [63:0] k, logic [31:0] h, logic [31:0] v);
      if (s >= CAP) return;
      tbl_key[s] = k;
      tbl_hash[s] = h;
      tbl_val[s] = v;
   endfunction

   function automatic bit lookup(logic [63:0] k, logic [31:0] h, output int slot);
      int  idx;
      bit  first;
      first = 1;
      slot = 0;
      if (n_entries == 0) return 0;
      idx = bucket_of(h, span, n_entries);
      for (int n = 0; n < CAP; n++) begin
         if (idx >= CAP) break;
         if (tbl_key[idx] == k) begin
            slot = idx;
            return 1;
         end
         if (first) begin
            first = 0;
            if (bucket_of(tbl_hash[idx], span, n_entries) != idx) break;
         end
         idx = tbl_link[idx];
      end
      return 0;
   endfunction

   function automatic int split(int empty);
      int half, first, idx, glo, ghi, pos;
      logic [3:0] flag;
      logic [63:0] lk, hk;
      logic [31:0] lh, hh, lv, hv, h;
      half = span >> 1;
      first = n_entries - half;
      idx = first;
      flag = '0; glo = 0; ghi = 0;
      lk = '0; hk = '0; lh = '0; hh = '0; lv = '0; hv = '0;
      if (half == 0) return empty;
      for (int n = 0; n < CAP; n++) begin
         pos = idx;
         if (pos >= CAP) break;
         h = tbl_hash[pos];
         if (flag == '0 && bucket_of(h, span, n_entries) != first) break;
         if ((h & half) == 0) begin
            if (!(flag & lht_pkg::LO_SEEN)) begin
               if (flag & lht_pkg::HI_SEEN) begin
                  flag = lht_pkg::LO_SEEN | lht_pkg::HI_SEEN;
                  glo = empty;
                  empty = pos;
               end else begin
                  flag = lht_pkg::LO_SEEN | lht_pkg::LO_SET;
                  glo = pos;
               end
            end else begin
               if (!(flag & lht_pkg::LO_SET)) begin
                  store(glo, lk, lh, lv);
                  tbl_link[glo] = pos;
                  flag = (flag & lht_pkg::HI_SEEN) | lht_pkg::LO_SEEN | lht_pkg::LO_SET;
               end
               glo = pos;
            end
            lk = tbl_key[pos]; lh = h; lv = tbl_val[pos];
         end else begin
            if (!(flag & lht_pkg::HI_SEEN)) begin
               flag = (flag & lht_pkg::LO_SEEN) | lht_pkg::HI_SEEN;
               ghi = empty;
               empty = pos;
            end else begin
               if (!(flag & lht_pkg::HI_SET)) begin
                  store(ghi, hk, hh, hv);
                  tbl_link[ghi] = pos;
                  flag = (flag & lht_pkg::LO_SEEN) | lht_pkg::HI_SEEN | lht_pkg::HI_SET;
               end
               ghi = pos;
            end
            hk = tbl_key[pos]; hh = h; hv = tbl_val[pos];
         end
         idx = tbl_link[pos];
      end
      if ((flag & (lht_pkg::LO_SEEN | lht_pkg::LO_SET)) == lht_pkg::LO_SEEN) begin
         store(glo, lk, lh, lv);
         tbl_link[glo] = NIL;
      end
      if ((flag & (lht_pkg::HI_SEEN | lht_pkg::HI_SET)) == lht_pkg::HI_SEEN) begin
         store(ghi, hk, hh, hv);
         tbl_link[ghi] = NIL;
      end
      return empty;
   endfunction

   function automatic void relink(int target, int from, int link_to);
      int cur, nxt;
      cur = from;
      for (int n = 0; n < CAP; n++) begin
         if (cur >= CAP) return;
         nxt = tbl_link[cur];
         if (nxt == target) begin
            tbl_link[cur] = link_to;
            return;
         end
         cur = nxt;
      end
   endfunction

   function automatic void place(logic [63:0] k, logic [31:0] h, logic [31:0] v);
      int empty, pos, home;
      empty = split(n_entries);
      pos = bucket_of(h, span, n_entries + 1);
      if (pos >= CAP || empty >= CAP) return;
      if (pos == empty) begin
         store(pos, k, h, v);
         tbl_link[pos] = NIL;
      end else begin
         store(empty, tbl_key[pos], tbl_hash[pos], tbl_val[pos]);
         tbl_link[empty] = tbl_link[pos];
         home = bucket_of(tbl_hash[pos], span, n_entries + 1);
         store(pos, k, h, v);
         if (home == pos) begin
            tbl_link[pos] = empty;
         end else begin
            tbl_link[pos] = NIL;
            relink(pos, home, empty);
         end
      end
   endfunction

   function automatic lht_pkg::rsp_type predict_op(lht_pkg::req_type r);
      lht_pkg::rsp_type o;
      int               slot;
      o = '0;
      if (r.kind == lht_pkg::KIND_SEARCH) begin
         if (lookup(r.key, r.key_hash, slot)) begin
            o.found = 1'b1;
            o.slot_index = slot[7:0];
            o.found_value = tbl_val[slot];
         end
         return o;
      end
      if (uniq && lookup(r.key, r.key_hash, slot)) begin
         o.status = lht_pkg::STATUS_DUP;
         return o;
      end
      if (n_entries >= CAP) begin
         o.status = lht_pkg::STATUS_FULL;
         return o;
      end
      place(r.key, r.key_hash, r.record_value);
      n_entries++;
      if (n_entries == span) span = span * 2;
      o.status = lht_pkg::STATUS_OK;
      return o;
   endfunction

   always @(posedge clock) begin
      lht_pkg::rsp_type e;
      if (reset) begin
         for (int i = 0; i < CAP; i++) begin
            tbl_key[i] = '0; tbl_hash[i] = '0; tbl_val[i] = '0; tbl_link[i] = 0;
         end
         n_entries = 0;
         span = 1;
         uniq = 1'b0;
         expected_q.delete();
         fail_count = 0;
         pending = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.found !== e.found) begin
                  $error("found: expected %0d, got %0d", e.found, rsp_data.found);
                  fail_count++;
               end
               if (rsp_data.slot_index !== e.slot_index) begin
                  $error("slot_index: expected %0d, got %0d", e.slot_index,
                         rsp_data.slot_index);
                  fail_count++;
               end
               if (rsp_data.found_value !== e.found_value) begin
                  $error("found_value: expected %h, got %h", e.found_value,
                         rsp_data.found_value);
                  fail_count++;
               end
            end
         end
         if (start && !busy) expected_q.push_back(predict_op(req_data));
         if (csr_valid && csr_ready) uniq = csr_wdata;
         pending = expected_q.size();
      end
   end

endmodule

### tb/tb_linear_hash_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_hash_table_unit
// Drives inserts and searches into the hash table unit over both settings
// of the unique-key register, with random gaps; the checker predicts results.
// ----------------------------------------------------------------------------
module tb_linear_hash_table_unit;

   localparam int LIMIT = 12000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   lht_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   lht_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic             csr_wdata = 1'b0;
   int               fail_count;
   int               pending;
   int               cycles = 0;
   bit               calm = 0;
   logic [63:0]      used_keys[$];
   logic [31:0]      used_hashes[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   linear_hash_table_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   lht_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_linear_hash_table_unit NOT OK");
         $finish;
      end
   end

   // Hold start high after the beat is taken: drain lowers it, the next issue only for a gap.
   task automatic issue(logic kind, logic [63:0] k, logic [31:0] h, logic [31:0] v);
      int gap;
      if (!calm && $urandom_range(3) == 0) begin
         gap = $urandom_range(14, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{kind: kind, key: k, key_hash: h, record_value: v};
      do @(posedge clock); while (busy);
      if (kind == lht_pkg::KIND_INSERT) begin
         used_keys.push_back(k);
         used_hashes.push_back(h);
      end
   endtask

   // Reuse a known key most of the time so searches hit and duplicates occur.
   task automatic random_op();
      logic [63:0] k;
      logic [31:0] h;
      int          i;
      k = {$urandom, $urandom};
      h = $urandom;
      if (used_keys.size() > 0 && $urandom_range(2) != 0) begin
         i = $urandom_range(used_keys.size() - 1);
         k = used_keys[i];
         h = used_hashes[i];
      end else if ($urandom_range(1)) begin
         h = h & 32'h1F;
      end
      issue(logic'($urandom_range(1)), k, h, $urandom);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_unique(logic v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, extremes of the fields
      issue(lht_pkg::KIND_SEARCH, '1, '1, '1);
      issue(lht_pkg::KIND_INSERT, '0, '0, '0);
      issue(lht_pkg::KIND_INSERT, '1, '1, '1);
      issue(lht_pkg::KIND_INSERT, 64'h5, '0, 32'h1234);
      issue(lht_pkg::KIND_SEARCH, '0, '0, '0);
      issue(lht_pkg::KIND_SEARCH, '1, '1, '0);
      issue(lht_pkg::KIND_SEARCH, 64'h5, '0, '0);
      issue(lht_pkg::KIND_SEARCH, 64'h77, 32'h3, '0);
      drain();
      write_unique(1'b1);
      issue(lht_pkg::KIND_INSERT, '1, '1, 32'hA5A5A5A5);
      issue(lht_pkg::KIND_INSERT, 64'h9, 32'h2, 32'h9);
      drain();
      write_unique(1'b0);

      // fill past capacity so full-table inserts are exercised
      for (int n = 0; n < 600; n++) random_op();
      drain();
      write_unique(1'b1);
      for (int n = 0; n < 100; n++) random_op();
      drain();

      // reset is not reissued, so keep working on the full table
      write_unique(1'b0);
      for (int n = 0; n < 300; n++) random_op();
      drain();
      write_unique(1'b1);
      calm = 1;
      for (int n = 0; n < 300; n++) random_op();
      drain();

      if (fail_count == 0)
         $display("tb_linear_hash_table_unit OK");
      else
         $display("tb_linear_hash_table_unit NOT OK");
      $finish;
   end

endmodule
